[src/dtc_pkg.sv]
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and codes for the decimal teaching cpu core.
// ----------------------------------------------------------------------------
package dtc_pkg;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        addr;
    logic signed [15:0] value;
    logic [7:0]         char_in;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [15:0]        pc_now;
    logic signed [15:0] instr;
    logic [7:0]         char_out;
    logic               is_running;
    logic               last;
  } out_word_t;

  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_MEMW = 2'd1;
  localparam logic [1:0] CMD_REGS = 2'd2;
  localparam logic [1:0] CMD_JUMP = 2'd3;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_HALT    = 4'd1;
  localparam logic [3:0] ST_HALTED  = 4'd2;
  localparam logic [3:0] ST_BADOP   = 4'd3;
  localparam logic [3:0] ST_BADREG  = 4'd4;
  localparam logic [3:0] ST_CHAR    = 4'd5;
  localparam logic [3:0] ST_STRCHR  = 4'd6;
  localparam logic [3:0] ST_STREND  = 4'd7;
  localparam logic [3:0] ST_DUMP    = 4'd8;
  localparam logic [3:0] ST_UNKIO   = 4'd9;

  localparam logic [3:0] OP_HLT  = 4'd0;
  localparam logic [3:0] OP_LD   = 4'd1;
  localparam logic [3:0] OP_ST   = 4'd2;
  localparam logic [3:0] OP_ADD  = 4'd3;
  localparam logic [3:0] OP_NEG  = 4'd4;
  localparam logic [3:0] OP_LDM  = 4'd5;
  localparam logic [3:0] OP_ADDM = 4'd6;
  localparam logic [3:0] OP_BR   = 4'd7;
  localparam logic [3:0] OP_BRC  = 4'd8;
  localparam logic [3:0] OP_IO   = 4'd9;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_DEC, S_DIG, S_EXEC, S_OPRD, S_WB, S_STR, S_STRW
  } state_t;

  // decoded instruction fields from the digit unit
  typedef struct packed {
    logic [3:0] op;
    logic [3:0] rd;
    logic [6:0] mm;
  } dec_t;

endpackage

[src/dtc_digits.sv]
// ----------------------------------------------------------------------------
// dtc_digits
// Iterative decimal splitter: magnitude into thousands, hundreds digit and
// remainder below 100 by repeated compare and subtract, one step a cycle.
// ----------------------------------------------------------------------------
module dtc_digits (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [15:0]        mag,
  output logic               done,
  output dtc_pkg::dec_t      dec
);

  logic [15:0] rem_r, rem_nxt;
  logic [5:0]  th_r, th_nxt;
  logic [3:0]  hu_r, hu_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // one subtract of 1000 or 100 per cycle
  always_comb begin
    rem_nxt  = rem_r;
    th_nxt   = th_r;
    hu_nxt   = hu_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt  = mag;
      th_nxt   = '0;
      hu_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= 16'd1000) begin
        rem_nxt = rem_r - 16'd1000;
        th_nxt  = th_r + 6'd1;
      end else if (rem_r >= 16'd100) begin
        rem_nxt = rem_r - 16'd100;
        hu_nxt  = hu_r + 4'd1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    th_r  <= th_nxt;
    hu_r  <= hu_nxt;
  end

  assign done   = done_r;
  assign dec.op = (th_r > 6'd9) ? 4'd15 : th_r[3:0];
  assign dec.rd = hu_r;
  assign dec.mm = rem_r[6:0];

endmodule

[src/decimal_teaching_cpu_core.sv]
// ----------------------------------------------------------------------------
// decimal_teaching_cpu_core
// Decimal-encoded 16-bit teaching cpu with register file and word memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each result word
// appears for one cycle with out_valid, out_word.last marks the final one,
// and the receiver cannot stall. After reset a clearing pass writes zero to
// every memory word with busy high. Memory writes, register sets, jumps and
// steps while halted go through the write-back state S_WB alone. In a step
// the compare-subtract digit unit peels the magnitude 1000 then 100 at a
// time (up to 40 iterations), and the single memory read port serves fetch
// and operand, so a memory load or add passes through an extra operand-read
// state. String output then reads one word at a time, S_STR then S_STRW,
// with one result each; at the length limit one more read gives the end word.
module decimal_teaching_cpu_core #(
  parameter int MEM_DEPTH  = 65536,
  parameter int NUM_REGS   = 8,
  parameter int MAX_STRING = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dtc_pkg::in_word_t   in_word,
  output logic                out_valid,
  output dtc_pkg::out_word_t  out_word
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int RW = $clog2(NUM_REGS);
  localparam int CW = $clog2(MAX_STRING + 1);

  dtc_pkg::state_t state_r, state_nxt;

  logic [15:0] mem [MEM_DEPTH];
  logic [15:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0] mem_wd;

  logic [15:0] regs_r [NUM_REGS];
  logic [15:0] pc_r, ir_r;
  logic        run_r;
  logic [AW:0] clr_r;
  dtc_pkg::in_word_t cmd_r;
  logic [AW-1:0] sa_r;
  logic [CW-1:0] cnt_r;

  logic          dg_go, dg_done;
  dtc_pkg::dec_t dec;
  logic          neg;
  logic [15:0]   mag, simm, rv;
  logic          rd_ok;

  logic          ov_r;
  dtc_pkg::out_word_t ow_r;

  assign neg   = ir_r[15];
  // magnitude of the word just fetched, taken by the digit unit on go
  assign mag   = rdata_r[15] ? (16'd0 - rdata_r) : rdata_r;
  assign simm  = neg ? (16'd0 - {9'd0, dec.mm}) : {9'd0, dec.mm};
  assign rd_ok = {28'd0, dec.rd} < NUM_REGS;
  assign rv    = regs_r[dec.rd[RW-1:0]];

  dtc_digits u_dig (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (dg_go),
    .mag  (mag),
    .done (dg_done),
    .dec  (dec)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtc_pkg::S_CLEAR: if (clr_r == (AW+1)'(MEM_DEPTH - 1)) state_nxt = dtc_pkg::S_IDLE;
      dtc_pkg::S_IDLE: begin
        if (start) begin
          if (in_word.cmd == dtc_pkg::CMD_STEP && run_r && 32'(pc_r) < 32'(MEM_DEPTH))
            state_nxt = dtc_pkg::S_FETCH;
          else
            state_nxt = dtc_pkg::S_WB;
        end
      end
      dtc_pkg::S_FETCH: state_nxt = dtc_pkg::S_DEC;
      dtc_pkg::S_DEC:   state_nxt = dtc_pkg::S_DIG;
      dtc_pkg::S_DIG:   if (dg_done) state_nxt = dtc_pkg::S_EXEC;
      dtc_pkg::S_EXEC: begin
        if (dec.op <= 4'd9 && dec.op == dtc_pkg::OP_IO && dec.rd == 4'd2)
          state_nxt = dtc_pkg::S_STR;
        else if (dec.op <= 4'd9 && (rd_ok || dec.op == dtc_pkg::OP_BR ||
                 dec.op == dtc_pkg::OP_HLT || dec.op == dtc_pkg::OP_IO) &&
                 (dec.op == dtc_pkg::OP_LD || dec.op == dtc_pkg::OP_ADD))
          state_nxt = dtc_pkg::S_OPRD;
        else
          state_nxt = dtc_pkg::S_IDLE;
      end
      dtc_pkg::S_OPRD: state_nxt = dtc_pkg::S_IDLE;
      dtc_pkg::S_WB:   state_nxt = dtc_pkg::S_IDLE;
      dtc_pkg::S_STR:  state_nxt = dtc_pkg::S_STRW;
      dtc_pkg::S_STRW: begin
        if (rdata_r == 16'd0 || 32'(cnt_r) == 32'(MAX_STRING)) state_nxt = dtc_pkg::S_IDLE;
        else state_nxt = dtc_pkg::S_STR;
      end
      default: state_nxt = dtc_pkg::S_IDLE;
    endcase
  end

  assign dg_go = (state_r == dtc_pkg::S_DEC);

  // memory address select
  always_comb begin
    mem_ra = pc_r[AW-1:0];
    case (state_r)
      dtc_pkg::S_EXEC: mem_ra = AW'(dec.mm);
      dtc_pkg::S_STR:  mem_ra = sa_r;
      default:         mem_ra = pc_r[AW-1:0];
    endcase
    mem_we = 1'b0;
    mem_wa = clr_r[AW-1:0];
    mem_wd = 16'd0;
    if (state_r == dtc_pkg::S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == dtc_pkg::S_IDLE && start && in_word.cmd == dtc_pkg::CMD_MEMW &&
                 32'(in_word.addr) < 32'(MEM_DEPTH)) begin
      mem_we = 1'b1;
      mem_wa = in_word.addr[AW-1:0];
      mem_wd = in_word.value;
    end else if (state_r == dtc_pkg::S_EXEC && dec.op == dtc_pkg::OP_ST && rd_ok) begin
      mem_we = 1'b1;
      mem_wa = AW'(dec.mm);
      mem_wd = rv;
    end
  end

  // word memory with one write port and one read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[mem_ra];
  end

  // datapath, registers and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtc_pkg::S_CLEAR;
      clr_r   <= '0;
      pc_r    <= '0;
      ir_r    <= '0;
      run_r   <= 1'b1;
      ov_r    <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= 1'b0;
      ow_r.last <= 1'b1;
      ow_r.instr <= ir_r;
      ow_r.char_out <= '0;
      case (state_r)
        dtc_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        dtc_pkg::S_IDLE: if (start) begin
          cmd_r <= in_word;
          ow_r.status <= dtc_pkg::ST_OK;
          if (in_word.cmd == dtc_pkg::CMD_STEP) begin
            if (!run_r) begin
              ow_r.status <= dtc_pkg::ST_HALTED;
            end else if (32'(pc_r) >= 32'(MEM_DEPTH)) begin
              run_r <= 1'b0;
              ow_r.status <= dtc_pkg::ST_HALT;
            end
          end else if (in_word.cmd == dtc_pkg::CMD_MEMW) begin
            if (32'(in_word.addr) < 32'(MEM_DEPTH)) run_r <= 1'b1;
          end else if (in_word.cmd == dtc_pkg::CMD_REGS) begin
            if (32'(in_word.addr) < 32'(NUM_REGS)) begin
              regs_r[in_word.addr[RW-1:0]] <= in_word.value;
              run_r <= 1'b1;
            end else ow_r.status <= dtc_pkg::ST_BADREG;
          end else begin
            if (32'(in_word.addr) < 32'(MEM_DEPTH)) pc_r <= in_word.addr;
          end
        end
        dtc_pkg::S_DEC: begin
          ir_r <= rdata_r;
          pc_r <= pc_r + 16'd1;
        end
        dtc_pkg::S_EXEC: begin
          ov_r <= 1'b1;
          ow_r.status <= dtc_pkg::ST_OK;
          // operand is below 100; the block does not check that memory holds at least 100 words
          sa_r <= AW'(dec.mm);
          cnt_r <= '0;
          if (dec.op > 4'd9) ow_r.status <= dtc_pkg::ST_BADOP;
          else if (dec.op != dtc_pkg::OP_HLT && dec.op != dtc_pkg::OP_BR &&
                   dec.op != dtc_pkg::OP_IO && !rd_ok) ow_r.status <= dtc_pkg::ST_BADREG;
          else case (dec.op)
            dtc_pkg::OP_HLT: begin
              run_r <= 1'b0;
              ow_r.status <= dtc_pkg::ST_HALT;
            end
            dtc_pkg::OP_LD, dtc_pkg::OP_ADD: ov_r <= 1'b0;
            dtc_pkg::OP_NEG: regs_r[dec.rd[RW-1:0]] <= 16'd0 - rv;
            dtc_pkg::OP_LDM: regs_r[dec.rd[RW-1:0]] <= simm;
            dtc_pkg::OP_ADDM: regs_r[dec.rd[RW-1:0]] <= rv + simm;
            dtc_pkg::OP_BR: pc_r <= {9'd0, dec.mm};
            dtc_pkg::OP_BRC:
              if ((!neg && rv != 16'd0 && !rv[15]) || (neg && rv[15])) pc_r <= {9'd0, dec.mm};
            dtc_pkg::OP_IO: begin
              if (dec.rd == 4'd0) regs_r[0] <= {{8{cmd_r.char_in[7]}}, cmd_r.char_in};
              else if (dec.rd == 4'd1) begin
                ow_r.status <= dtc_pkg::ST_CHAR;
                ow_r.char_out <= regs_r[0][7:0];
              end else if (dec.rd == 4'd2) ov_r <= 1'b0;
              else if (dec.rd == 4'd3 || dec.rd == 4'd4) ow_r.status <= dtc_pkg::ST_DUMP;
              else ow_r.status <= dtc_pkg::ST_UNKIO;
            end
            default: ow_r.status <= dtc_pkg::ST_OK;
          endcase
        end
        dtc_pkg::S_OPRD: begin
          ov_r <= 1'b1;
          ow_r.status <= dtc_pkg::ST_OK;
          if (cmd_r.cmd == dtc_pkg::CMD_STEP) begin
            if (dec.op == dtc_pkg::OP_LD) regs_r[dec.rd[RW-1:0]] <= rdata_r;
            else regs_r[dec.rd[RW-1:0]] <= rv + rdata_r;
          end
        end
        dtc_pkg::S_WB: begin
          ov_r <= 1'b1;
          ow_r.instr <= '0;
          ow_r.status <= ow_r.status;
        end
        dtc_pkg::S_STR: sa_r <= (32'(sa_r) == MEM_DEPTH - 1) ? '0 : sa_r + 1'b1;
        dtc_pkg::S_STRW: begin
          ov_r <= 1'b1;
          // zero word or length limit: end word
          if (rdata_r == 16'd0 || 32'(cnt_r) == 32'(MAX_STRING)) begin
            ow_r.status <= dtc_pkg::ST_STREND;
          end else begin
            ow_r.status <= dtc_pkg::ST_STRCHR;
            ow_r.char_out <= rdata_r[7:0];
            ow_r.last <= 1'b0;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result word, with live pc and running flag
  always_comb begin
    out_word.status     = ow_r.status;
    out_word.pc_now     = pc_r;
    out_word.instr      = ow_r.instr;
    out_word.char_out   = ow_r.char_out;
    out_word.is_running = run_r;
    out_word.last       = ow_r.last;
    out_valid           = ov_r;
  end

  assign busy = (state_r != dtc_pkg::S_IDLE);

  // end words of a string pair with last
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == dtc_pkg::ST_STREND |-> out_word.last)
    else $error("string end without last");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dtc_pkg::S_DIG |-> busy)
    else $error("idle during decode");
  a_chr_notlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == dtc_pkg::ST_STRCHR |-> !out_word.last)
    else $error("string char marked last");

endmodule
